// File: hw/rtl/ecls_pkg.sv
// Package of the emoji cluster length scanner: widths, code point constants,
// scan state codes and the structs shared by the top level and the step logic.
// Depends on nothing.
`default_nettype none

package ecls_pkg;

    // Width of the running count; the reported length is always 8 bits.
    localparam int COUNT_WIDTH = 8;
    localparam int SUM_W       = COUNT_WIDTH + 1;
    localparam int OUT_W       = 8;
    localparam int EXT_W       = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [OUT_W-1:0]       LEN_MAX   = {OUT_W{1'b1}};

    localparam int CP_W = 21;

    // Configuration register indexes.
    localparam logic CFG_SCAN_BACKWARD   = 1'b0;
    localparam logic CFG_COUNT_NON_EMOJI = 1'b1;

    // Code points with a role of their own.
    localparam logic [CP_W-1:0] CP_LF        = 21'h0000A;
    localparam logic [CP_W-1:0] CP_CR        = 21'h0000D;
    localparam logic [CP_W-1:0] CP_KEYCAP    = 21'h020E3;
    localparam logic [CP_W-1:0] CP_ZWJ       = 21'h0200D;
    localparam logic [CP_W-1:0] CP_CANCEL    = 21'hE007F;
    localparam logic [CP_W-1:0] CP_TAG_LO    = 21'hE0020;
    localparam logic [CP_W-1:0] CP_TAG_HI    = 21'hE007E;
    localparam logic [CP_W-1:0] CP_HANDSHAKE = 21'h1F91D;
    localparam logic [CP_W-1:0] CP_WRESTLERS = 21'h1F93C;
    localparam logic [CP_W-1:0] CP_DIGIT_LO  = 21'h00030;
    localparam logic [CP_W-1:0] CP_DIGIT_HI  = 21'h00039;
    localparam logic [CP_W-1:0] CP_HASH      = 21'h00023;
    localparam logic [CP_W-1:0] CP_STAR      = 21'h0002A;

    // Scan state codes.
    localparam logic [3:0] S_BEGIN      = 4'd0;
    localparam logic [3:0] S_SECOND     = 4'd1;
    localparam logic [3:0] S_MOD        = 4'd2;
    localparam logic [3:0] S_SEL_KEYCAP = 4'd3;
    localparam logic [3:0] S_JOIN       = 4'd4;
    localparam logic [3:0] S_KEYCAP     = 4'd5;
    localparam logic [3:0] S_PICT       = 4'd6;
    localparam logic [3:0] S_SEL_MOD    = 4'd7;
    localparam logic [3:0] S_SEL        = 4'd8;
    localparam logic [3:0] S_SEL_JOIN   = 4'd9;
    localparam logic [3:0] S_LF         = 4'd10;
    localparam logic [3:0] S_CR         = 4'd11;
    localparam logic [3:0] S_TAGS       = 4'd12;
    localparam logic [3:0] S_RI_EVEN    = 4'd13;
    localparam logic [3:0] S_RI_ODD     = 4'd14;
    localparam logic [3:0] S_DONE       = 4'd15;

    // One input word as held in the input register.
    typedef struct packed {
        logic            start_scan;
        logic            last_item;
        logic [CP_W-1:0] code_point;
        logic            prop_emoji;
        logic            prop_modifier;
        logic            prop_modifier_base;
        logic            prop_variation_sel;
        logic            prop_regional;
        logic            class_zero;
    } t_item;

    // Scan state carried from one word to the next.
    typedef struct packed {
        logic [3:0]             state;
        logic [COUNT_WIDTH-1:0] count;
        logic                   pending;
        logic                   done;
        logic                   overflow;
    } t_scan_regs;

    typedef struct packed {
        logic scan_backward;
        logic count_non_emoji;
    } t_cfg;

    // Result of one step: whether a word goes out, and its fields.
    typedef struct packed {
        logic             emit;
        logic [OUT_W-1:0] len;
        logic             sat;
    } t_step_out;

endpackage

`default_nettype wire

// File: hw/rtl/ecls_if.sv
// Valid/ready channels of the emoji cluster length scanner: the code point
// input channel and the result channel. Depends on ecls_pkg.
`default_nettype none

interface ecls_item_if;
    import ecls_pkg::*;

    logic            valid;
    logic            ready;
    logic            start_scan;
    logic            last_item;
    logic [CP_W-1:0] code_point;
    logic            prop_emoji;
    logic            prop_modifier;
    logic            prop_modifier_base;
    logic            prop_variation_sel;
    logic            prop_regional;
    logic            class_zero;

    modport source (
        output valid, start_scan, last_item, code_point, prop_emoji, prop_modifier,
               prop_modifier_base, prop_variation_sel, prop_regional, class_zero,
        input  ready
    );
    modport sink (
        input  valid, start_scan, last_item, code_point, prop_emoji, prop_modifier,
               prop_modifier_base, prop_variation_sel, prop_regional, class_zero,
        output ready
    );
endinterface

interface ecls_result_if;
    import ecls_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] cluster_length;
    logic             length_saturated;

    modport source (
        output valid, cluster_length, length_saturated,
        input  ready
    );
    modport sink (
        input  valid, cluster_length, length_saturated,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/ecls_step.sv
// Next-state logic of the cluster scanner: applies one code point to the
// scan state and decides whether a result goes out. Depends on ecls_pkg.
`default_nettype none

module ecls_step (
    input  wire ecls_pkg::t_scan_regs i_cur,
    input  wire ecls_pkg::t_item      i_item,
    input  wire ecls_pkg::t_cfg       i_cfg,
    output ecls_pkg::t_scan_regs      o_nxt,
    output ecls_pkg::t_step_out       o_out
);
    import ecls_pkg::*;

    logic bw;
    logic is_lf, is_cr, is_keycap, is_zwj, is_cancel, is_tag, is_kbase;
    logic emo, mod, base, vs, ri;

    // Code point decodes.
    assign bw        = i_cfg.scan_backward;
    assign emo       = i_item.prop_emoji;
    assign mod       = i_item.prop_modifier;
    assign vs        = i_item.prop_variation_sel;
    assign ri        = i_item.prop_regional;
    assign is_lf     = (i_item.code_point == CP_LF);
    assign is_cr     = (i_item.code_point == CP_CR);
    assign is_keycap = (i_item.code_point == CP_KEYCAP);
    assign is_zwj    = (i_item.code_point == CP_ZWJ);
    assign is_cancel = (i_item.code_point == CP_CANCEL);
    assign base      = i_item.prop_modifier_base || (i_item.code_point == CP_HANDSHAKE)
                       || (i_item.code_point == CP_WRESTLERS);
    assign is_tag    = i_item.code_point inside {[CP_TAG_LO:CP_TAG_HI]};
    assign is_kbase  = i_item.code_point inside {[CP_DIGIT_LO:CP_DIGIT_HI], CP_HASH, CP_STAR};

    // State transition, count update and result decision for one word.
    always_comb begin
        t_scan_regs       w;
        logic [3:0]       s;
        logic [1:0]       add_n;
        logic             plain;
        logic [SUM_W-1:0] sum;
        logic [EXT_W-1:0] ext;

        w     = i_cur;
        add_n = 2'd0;
        plain = 1'b0;
        ext   = '0;
        o_out = '0;

        // A start word clears the scan, even in the middle of one.
        if (i_item.start_scan) begin
            w.state    = S_BEGIN;
            w.count    = '0;
            w.pending  = 1'b0;
            w.overflow = 1'b0;
            w.done     = 1'b0;
        end
        s = w.state;

        case (s)
            S_BEGIN: begin
                w.count = COUNT_WIDTH'(1);
                if (is_lf) s = S_LF;
                else if (vs) s = S_SEL;
                else if (is_cr) s = bw ? S_DONE : S_CR;
                else if (ri) s = bw ? S_RI_ODD : S_RI_EVEN;
                else if (mod) s = S_MOD;
                else if (is_keycap) s = S_KEYCAP;
                else if (emo) s = S_PICT;
                else if (is_cancel) s = S_TAGS;
                else begin
                    plain = 1'b1;
                    s = bw ? S_DONE : S_SECOND;
                end
            end
            S_SECOND: begin
                if (bw) s = S_DONE;
                else if (vs) begin add_n = 2'd1; s = S_SEL; end
                else if (is_keycap) begin add_n = 2'd1; s = S_KEYCAP; end
                else s = S_DONE;
            end
            S_CR: begin
                if (!bw && is_lf) add_n = 2'd1;
                s = S_DONE;
            end
            S_LF: begin
                if (bw && is_cr) add_n = 2'd1;
                s = S_DONE;
            end
            S_RI_ODD: begin
                if (bw && ri) begin add_n = 2'd1; s = S_RI_EVEN; end
                else s = S_DONE;
            end
            S_RI_EVEN: begin
                if (!bw && ri) begin add_n = 2'd1; s = S_RI_ODD; end
                else s = S_DONE;
            end
            S_KEYCAP: begin
                if (bw && vs) begin
                    w.pending = 1'b1;
                    s = S_SEL_KEYCAP;
                end else begin
                    if (bw && base) add_n = 2'd1;
                    s = S_DONE;
                end
            end
            S_SEL_KEYCAP: begin
                if (bw && is_kbase) add_n = {1'b0, w.pending} + 2'd1;
                s = S_DONE;
            end
            S_MOD: begin
                if (bw) begin
                    if (vs) begin
                        w.pending = 1'b1;
                        s = S_SEL_MOD;
                    end else begin
                        if (base) add_n = 2'd1;
                        s = S_DONE;
                    end
                end else if (emo) begin add_n = 2'd1; s = S_PICT; end
                else if (vs) begin add_n = 2'd1; s = S_SEL; end
                else if (is_zwj) begin add_n = 2'd1; s = S_JOIN; end
                else begin
                    if (base) add_n = 2'd1;
                    s = S_DONE;
                end
            end
            S_SEL_MOD: begin
                if (bw && base) add_n = {1'b0, w.pending} + 2'd1;
                s = S_DONE;
            end
            S_SEL: begin
                if (bw) begin
                    if (emo) begin add_n = 2'd1; s = S_PICT; end
                    else begin
                        if (!vs && i_item.class_zero) add_n = 2'd1;
                        s = S_DONE;
                    end
                end else if (is_zwj) begin add_n = 2'd1; s = S_JOIN; end
                else if (is_keycap) begin add_n = 2'd1; s = S_KEYCAP; end
                else s = S_DONE;
            end
            S_PICT: begin
                if (bw) s = is_zwj ? S_JOIN : S_DONE;
                else if (is_zwj) begin add_n = 2'd1; s = S_JOIN; end
                else if (vs) begin add_n = 2'd1; s = S_SEL; end
                else if (mod) begin add_n = 2'd1; s = S_MOD; end
                else if (is_tag) begin add_n = 2'd1; s = S_TAGS; end
                else s = S_DONE;
            end
            S_JOIN: begin
                if (bw) begin
                    if (emo) begin
                        add_n = 2'd2;
                        s = mod ? S_MOD : S_PICT;
                    end else if (vs) begin
                        w.pending = 1'b1;
                        s = S_SEL_JOIN;
                    end else s = S_DONE;
                end else if (emo) begin add_n = 2'd1; s = S_PICT; end
                else s = S_DONE;
            end
            S_SEL_JOIN: begin
                if (bw && emo) begin
                    add_n = 2'd2 + {1'b0, w.pending};
                    w.pending = 1'b0;
                    s = S_PICT;
                end else s = S_DONE;
            end
            S_TAGS: begin
                if (bw) begin
                    add_n = 2'd1;
                    if (!is_tag) s = S_DONE;
                end else if (is_tag) add_n = 2'd1;
                else if (emo) s = S_DONE;
                else begin add_n = 2'd1; s = S_DONE; end
            end
            default: begin
                s = S_DONE;
            end
        endcase

        // Saturating count update.
        sum = {1'b0, w.count} + SUM_W'(add_n);
        if (sum > {1'b0, COUNT_MAX}) begin
            w.count    = COUNT_MAX;
            w.overflow = 1'b1;
        end else begin
            w.count = sum[COUNT_WIDTH-1:0];
        end
        w.state = s;

        // End of scan: a plain start without counting reports zero; otherwise
        // the count reached goes out, capped to the output width.
        if (plain && !i_cfg.count_non_emoji) begin
            w.state    = S_DONE;
            w.done     = 1'b1;
            w.count    = '0;
            o_out.emit = 1'b1;
        end else if (s == S_DONE || i_item.last_item) begin
            w.state    = S_DONE;
            w.done     = 1'b1;
            o_out.emit = 1'b1;
            ext = EXT_W'(w.count);
            if (ext > EXT_W'(LEN_MAX)) begin
                o_out.len = LEN_MAX;
                o_out.sat = 1'b1;
            end else begin
                o_out.len = ext[OUT_W-1:0];
                o_out.sat = w.overflow;
            end
        end

        // Between scans, words without a start are dropped.
        if (i_item.start_scan || !i_cur.done) begin
            o_nxt = w;
        end else begin
            o_nxt = i_cur;
            o_out = '0;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/emoji_cluster_length_scanner.sv
// Top level of the emoji cluster length scanner: input register, step logic
// and result register. Depends on ecls_pkg, ecls_if.sv and ecls_step.
//
// Usage: code points arrive one word per cycle on i_item, each with the
// property flags from an upstream classifier. A word with start_scan opens a
// scan; words after it walk the string backward or forward as scan_backward
// selects. When the cluster ends, or on the word with last_item, one result
// word (cluster_length, length_saturated) goes out on o_result. Words that
// arrive between scans without start_scan are dropped.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 scan_backward, 1 count_non_emoji); write only while the block is idle.
// The word that ends the scan waits in the input register; its result is
// registered in the result register as it moves on. Throughput: one word per
// cycle unless stalled, set by the state update between the two registers.
// Stall: while the result register is full and not taken, the input register
// holds its word and i_item.ready falls once it is occupied as well.
// Reset: synchronous, active low; both registers empty, configuration back
// to backward scan with plain characters counted, no scan open.
`default_nettype none

module emoji_cluster_length_scanner (
    input  wire             i_clk,
    input  wire             i_rst_n,
    ecls_item_if.sink       i_item,
    ecls_result_if.source   o_result,
    input  wire             i_cfg_we,
    input  wire             i_cfg_idx,
    input  wire             i_cfg_data
);
    import ecls_pkg::*;

    t_item      r_s1_item;
    logic       r_s1_valid;
    t_scan_regs r_st;
    t_scan_regs n_st;
    t_cfg       r_cfg;
    t_step_out  step_out;
    logic       r_out_valid;
    logic [OUT_W-1:0] r_out_len;
    logic       r_out_sat;
    logic       s1_adv;
    logic       in_take;

    // The held word moves on when the result register has room.
    assign s1_adv       = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_s1_valid || s1_adv;
    assign in_take      = i_item.valid && i_item.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item.start_scan         <= i_item.start_scan;
            r_s1_item.last_item          <= i_item.last_item;
            r_s1_item.code_point         <= i_item.code_point;
            r_s1_item.prop_emoji         <= i_item.prop_emoji;
            r_s1_item.prop_modifier      <= i_item.prop_modifier;
            r_s1_item.prop_modifier_base <= i_item.prop_modifier_base;
            r_s1_item.prop_variation_sel <= i_item.prop_variation_sel;
            r_s1_item.prop_regional      <= i_item.prop_regional;
            r_s1_item.class_zero         <= i_item.class_zero;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_backward   <= 1'b1;
            r_cfg.count_non_emoji <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCAN_BACKWARD:   r_cfg.scan_backward   <= i_cfg_data;
                CFG_COUNT_NON_EMOJI: r_cfg.count_non_emoji <= i_cfg_data;
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    ecls_step u_step (
        .i_cur  (r_st),
        .i_item (r_s1_item),
        .i_cfg  (r_cfg),
        .o_nxt  (n_st),
        .o_out  (step_out)
    );

    // Scan state register, updated once per word that moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.state    <= S_BEGIN;
            r_st.count    <= '0;
            r_st.pending  <= 1'b0;
            r_st.done     <= 1'b1;
            r_st.overflow <= 1'b0;
        end else if (s1_adv) begin
            r_st <= n_st;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && step_out.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && step_out.emit) begin
            r_out_len <= step_out.len;
            r_out_sat <= step_out.sat;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.cluster_length   = r_out_len;
    assign o_result.length_saturated = r_out_sat;

    // A new result word only follows a word that moved on and ended a scan.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_adv && step_out.emit))
        else $error("result word appeared without an ending input word");

    // A result closes the scan.
    a_done_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && step_out.emit) |=> (r_st.done && r_st.state == S_DONE))
        else $error("scan still open after its result");

    // The overflow flag is only set with the count pinned at its maximum.
    a_overflow_pinned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.overflow |-> (r_st.count == COUNT_MAX))
        else $error("overflow flag set below the count maximum");

endmodule

`default_nettype wire
